@@ sv/adc_spi_reader_with_deadband_defines.svh @@
`ifndef ADC_SPI_READER_WITH_DEADBAND_DEFINES_SVH
`define ADC_SPI_READER_WITH_DEADBAND_DEFINES_SVH

// Concurrent check on the rising edge, disabled while reset is asserted.
`define ADCDB_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

// Condition that must never be seen on a rising edge out of reset.
`define ADCDB_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error(msg);

`endif

@@ sv/adcdb_pkg.sv @@
`timescale 1ns / 1ps

package adcdb_pkg;

	localparam int CHANNELS  = 8;
	localparam int READ_BITS = 12;

	localparam int CH_W     = 3;
	localparam int SAMPLE_W = 10;
	localparam int CMD_W    = 5;
	localparam int EVENT_W  = 6;

	localparam logic [SAMPLE_W-1:0] TOL_RESET = SAMPLE_W'(5);

	// event 0 drops select, 1..15 send the command, then two events per read bit
	localparam logic [EVENT_W-1:0] CMD_EVENTS       = EVENT_W'(15);
	localparam logic [EVENT_W-1:0] READ_FIRST_EVENT = EVENT_W'(16);
	localparam logic [EVENT_W-1:0] LAST_EVENT       = EVENT_W'(16 + 2 * READ_BITS);

	typedef enum logic {
		OP_START = 1'b0,
		OP_TICK  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		PH_DATA = 2'd0,
		PH_RISE = 2'd1,
		PH_FALL = 2'd2
	} cmd_phase_t;

	typedef struct packed {
		logic                cs_n;
		logic                sclk;
		logic                mosi;
		logic                busy;
		logic                done;
		logic [SAMPLE_W-1:0] sample;
		logic [CH_W-1:0]     channel;
	} seq_res_t;

endpackage

@@ sv/adcdb_seq.sv @@
`timescale 1ns / 1ps

module adcdb_seq (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          fire,
	input  adcdb_pkg::op_t                op,
	input  logic [adcdb_pkg::CH_W-1:0]    ch,
	input  logic                          miso,
	output adcdb_pkg::seq_res_t           res
);

	logic [adcdb_pkg::EVENT_W-1:0]   event_q, event_d;
	logic                            active_q, active_d;
	logic [adcdb_pkg::CH_W-1:0]      cur_ch_q, cur_ch_d;
	logic [adcdb_pkg::CMD_W-1:0]     cmd_q, cmd_d;
	logic [adcdb_pkg::READ_BITS-1:0] rd_q, rd_d;
	adcdb_pkg::cmd_phase_t           phase_q, phase_d;
	logic                            cs_n_q, cs_n_d;
	logic                            sclk_q, sclk_d;
	logic                            mosi_q, mosi_d;
	logic                            done;
	logic [adcdb_pkg::EVENT_W-1:0]   read_off;

	assign read_off = event_q - adcdb_pkg::READ_FIRST_EVENT;

	always_comb begin
		event_d  = event_q;
		active_d = active_q;
		cur_ch_d = cur_ch_q;
		cmd_d    = cmd_q;
		rd_d     = rd_q;
		phase_d  = phase_q;
		cs_n_d   = cs_n_q;
		sclk_d   = sclk_q;
		mosi_d   = mosi_q;
		done     = 1'b0;
		if (fire) begin
			if (op == adcdb_pkg::OP_START) begin
				if (!active_q && (int'(ch) < adcdb_pkg::CHANNELS)) begin
					active_d = 1'b1;
					cur_ch_d = ch;
					event_d  = '0;
					cmd_d    = {2'b11, ch};
					rd_d     = '0;
					phase_d  = adcdb_pkg::PH_DATA;
				end
			end else if (active_q) begin
				event_d = event_q + 1'b1;
				if (event_q == '0) begin
					cs_n_d = 1'b0;
					sclk_d = 1'b0;
				end else if (event_q <= adcdb_pkg::CMD_EVENTS) begin
					case (phase_q)
						adcdb_pkg::PH_DATA: begin
							mosi_d  = cmd_q[adcdb_pkg::CMD_W-1];
							cmd_d   = {cmd_q[adcdb_pkg::CMD_W-2:0], 1'b0};
							phase_d = adcdb_pkg::PH_RISE;
						end
						adcdb_pkg::PH_RISE: begin
							sclk_d  = 1'b1;
							phase_d = adcdb_pkg::PH_FALL;
						end
						default: begin
							sclk_d  = 1'b0;
							phase_d = adcdb_pkg::PH_DATA;
						end
					endcase
				end else if (event_q < adcdb_pkg::LAST_EVENT) begin
					if (!read_off[0]) begin
						sclk_d = 1'b1;
					end else begin
						sclk_d = 1'b0;
						rd_d   = {rd_q[adcdb_pkg::READ_BITS-2:0], miso};
					end
				end else begin
					// end of frame: raise select and report
					cs_n_d   = 1'b1;
					active_d = 1'b0;
					event_d  = '0;
					done     = 1'b1;
				end
			end
		end
	end

	always_comb begin
		res.cs_n    = cs_n_d;
		res.sclk    = sclk_d;
		res.mosi    = mosi_d;
		res.busy    = active_d;
		res.done    = done;
		res.sample  = done ? rd_q[adcdb_pkg::SAMPLE_W:1] : '0;
		res.channel = done ? cur_ch_q : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			event_q  <= '0;
			active_q <= 1'b0;
			cur_ch_q <= '0;
			cmd_q    <= '0;
			rd_q     <= '0;
			phase_q  <= adcdb_pkg::PH_DATA;
			cs_n_q   <= 1'b1;
			sclk_q   <= 1'b0;
			mosi_q   <= 1'b0;
		end else begin
			event_q  <= event_d;
			active_q <= active_d;
			cur_ch_q <= cur_ch_d;
			cmd_q    <= cmd_d;
			rd_q     <= rd_d;
			phase_q  <= phase_d;
			cs_n_q   <= cs_n_d;
			sclk_q   <= sclk_d;
			mosi_q   <= mosi_d;
		end
	end

endmodule

@@ sv/adcdb_deadband.sv @@
`timescale 1ns / 1ps

module adcdb_deadband (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              wr,
	input  logic [adcdb_pkg::CH_W-1:0]        ch,
	input  logic [adcdb_pkg::SAMPLE_W-1:0]    sample,
	input  logic [adcdb_pkg::SAMPLE_W-1:0]    tolerance,
	output logic                              changed
);

	logic [adcdb_pkg::SAMPLE_W-1:0] prev_q [adcdb_pkg::CHANNELS];
	logic                           ch_ok;
	logic [adcdb_pkg::SAMPLE_W-1:0] prev;
	logic [adcdb_pkg::SAMPLE_W:0]   s_plus_tol;
	logic [adcdb_pkg::SAMPLE_W:0]   p_plus_tol;

	assign ch_ok = int'(ch) < adcdb_pkg::CHANNELS;
	assign prev  = ch_ok ? prev_q[ch] : '0;

	// outside the band: prev - tol > s, or prev + tol < s
	assign s_plus_tol = {1'b0, sample} + {1'b0, tolerance};
	assign p_plus_tol = {1'b0, prev} + {1'b0, tolerance};
	assign changed    = ({1'b0, prev} > s_plus_tol) || (p_plus_tol < {1'b0, sample});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < adcdb_pkg::CHANNELS; i++) begin
				prev_q[i] <= '0;
			end
		end else if (wr && ch_ok) begin
			prev_q[ch] <= sample;
		end
	end

endmodule

@@ sv/adc_spi_reader_with_deadband.sv @@
// A beat accepted into the input stage moves to the result stage once the result slot is free.
// One beat per cycle while the result stage is not stalled; sequencer and deadband compare are combinational.
// A stalled result stage holds one more beat in the input stage, then drops in_ready.
// Reset (arst_n low, async): sequencer idle, select high, clock and data low,
// tolerance 5, per-channel previous samples cleared to zero at once; no clearing pass.
`timescale 1ns / 1ps
`include "adc_spi_reader_with_deadband_defines.svh"

module adc_spi_reader_with_deadband (
	input  logic                                clk,
	input  logic                                arst_n,
	// tolerance register write
	input  logic                                cfg_we,
	input  logic [adcdb_pkg::SAMPLE_W-1:0]      cfg_wdata,
	// input channel
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                operation,
	input  logic [adcdb_pkg::CH_W-1:0]          channel,
	input  logic                                miso,
	// result channel
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                cs_n,
	output logic                                sclk,
	output logic                                mosi,
	output logic                                busy_res,
	output logic                                done_res,
	output logic [adcdb_pkg::SAMPLE_W-1:0]      sample,
	output logic [adcdb_pkg::CH_W-1:0]          sample_channel,
	output logic                                changed
);

	logic [adcdb_pkg::SAMPLE_W-1:0] tolerance_q;

	// input stage
	logic                           valid_s1;
	adcdb_pkg::op_t                 op_s1;
	logic [adcdb_pkg::CH_W-1:0]     ch_s1;
	logic                           miso_s1;

	// result stage
	logic                           valid_s2;
	adcdb_pkg::seq_res_t            res_s2;
	logic                           changed_s2;

	logic                           in_fire;
	logic                           advance;
	adcdb_pkg::seq_res_t            seq_res;
	logic                           db_changed;

	// Advance the input stage whenever the result slot is free or drains this cycle.
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign in_fire  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tolerance_q <= adcdb_pkg::TOL_RESET;
		end else if (cfg_we) begin
			tolerance_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// hold payload until the stage is reloaded
	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_s1   <= adcdb_pkg::op_t'(operation);
			ch_s1   <= channel;
			miso_s1 <= miso;
		end
	end

	// Pin sequencer: one pin event per tick beat while a conversion is active, state moves only when the beat advances.
	adcdb_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.op     (op_s1),
		.ch     (ch_s1),
		.miso   (miso_s1),
		.res    (seq_res)
	);

	// Deadband compare against the last sample of the channel, store updated on done.
	adcdb_deadband u_deadband (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (advance && seq_res.done),
		.ch        (seq_res.channel),
		.sample    (seq_res.sample),
		.tolerance (tolerance_q),
		.changed   (db_changed)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2     <= seq_res;
			changed_s2 <= seq_res.done && db_changed;
		end
	end

	assign out_valid      = valid_s2;
	assign cs_n           = res_s2.cs_n;
	assign sclk           = res_s2.sclk;
	assign mosi           = res_s2.mosi;
	assign busy_res       = res_s2.busy;
	assign done_res       = res_s2.done;
	assign sample         = res_s2.sample;
	assign sample_channel = res_s2.channel;
	assign changed        = changed_s2;

	`ADCDB_ASSERT(a_done_ends_frame, clk, arst_n, (out_valid && done_res) |-> (cs_n && !busy_res), "done beat must raise select and clear busy")
	`ADCDB_ASSERT_NEVER(a_idle_fields_zero, clk, arst_n, out_valid && !done_res && (changed || (sample != '0)), "sample fields set on a beat without done")
	`ADCDB_ASSERT(a_idle_select_high, clk, arst_n, (out_valid && !busy_res) |-> cs_n, "select low while sequencer idle")
	`ADCDB_ASSERT(a_stage_moves, clk, arst_n, (valid_s1 && !valid_s2) |=> valid_s2, "input stage did not reach the result slot")

endmodule

@@ test/adc_spi_reader_with_deadband_checker.sv @@
`timescale 1ns / 1ps

module adc_spi_reader_with_deadband_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [adcdb_pkg::SAMPLE_W-1:0]     cfg_wdata,
	input  logic                               in_valid,
	input  logic                               in_ready,
	input  logic                               operation,
	input  logic [adcdb_pkg::CH_W-1:0]         channel,
	input  logic                               miso,
	input  logic                               out_valid,
	input  logic                               out_ready,
	input  logic                               cs_n,
	input  logic                               sclk,
	input  logic                               mosi,
	input  logic                               busy_res,
	input  logic                               done_res,
	input  logic [adcdb_pkg::SAMPLE_W-1:0]     sample,
	input  logic [adcdb_pkg::CH_W-1:0]         sample_channel,
	input  logic                               changed,
	output int                                 errors,
	output int                                 pending,
	output int                                 conversions
);
	import adcdb_pkg::*;

	typedef struct packed {
		logic                cs_n;
		logic                sclk;
		logic                mosi;
		logic                busy;
		logic                done;
		logic [SAMPLE_W-1:0] sample;
		logic [CH_W-1:0]     chan;
		logic                changed;
	} pin_state_t;

	pin_state_t pin_state_q [$];
	pin_state_t want;
	pin_state_t next_state;
	int         beat_no;

	// sequencer copy
	logic [SAMPLE_W-1:0]  tol;
	logic [EVENT_W-1:0]   ev_cnt;
	logic                 seq_active;
	logic [CH_W-1:0]      seq_ch;
	logic [CMD_W-1:0]     cmd_sr;
	logic [READ_BITS-1:0] rd_sr;
	logic                 p_cs_n;
	logic                 p_sclk;
	logic                 p_mosi;
	logic [SAMPLE_W-1:0]  last_sample [CHANNELS];

	task automatic reset_sequencer();
		tol        = TOL_RESET;
		ev_cnt     = '0;
		seq_active = 1'b0;
		seq_ch     = '0;
		cmd_sr     = '0;
		rd_sr      = '0;
		p_cs_n     = 1'b1;
		p_sclk     = 1'b0;
		p_mosi     = 1'b0;
		foreach (last_sample[i])
			last_sample[i] = '0;
		pin_state_q.delete();
	endtask

	// Advance the sequencer by one beat and return the pin levels it leaves.
	task automatic step_sequencer(input op_t op, input logic [CH_W-1:0] ch, input logic mi,
			output pin_state_t r);
		logic [SAMPLE_W-1:0] s;
		int                  lo;
		int                  hi;
		logic                ended;

		r     = '0;
		ended = 1'b0;
		if (op == OP_START) begin
			if (!seq_active && ch < CHANNELS) begin
				seq_active = 1'b1;
				seq_ch     = ch;
				ev_cnt     = '0;
				cmd_sr     = {2'b11, ch};
				rd_sr      = '0;
			end
		end else if (seq_active) begin
			if (ev_cnt == 0) begin
				p_cs_n = 1'b0;
				p_sclk = 1'b0;
			end else if (ev_cnt <= CMD_EVENTS) begin
				case (cmd_phase_t'(2'((ev_cnt - 1) % 3)))
					PH_DATA: begin
						p_mosi = cmd_sr[CMD_W-1];
						cmd_sr = cmd_sr << 1;
					end
					PH_RISE: p_sclk = 1'b1;
					default: p_sclk = 1'b0;
				endcase
			end else if (ev_cnt < LAST_EVENT) begin
				// read pulses start on an even event: rise, then fall and sample
				if (!ev_cnt[0]) begin
					p_sclk = 1'b1;
				end else begin
					p_sclk = 1'b0;
					rd_sr  = {rd_sr[READ_BITS-2:0], mi};
				end
			end else begin
				s  = rd_sr[SAMPLE_W:1];
				lo = int'(last_sample[seq_ch]) - int'(tol);
				hi = int'(last_sample[seq_ch]) + int'(tol);
				r.changed = (lo > int'(s)) || (hi < int'(s));
				last_sample[seq_ch] = s;
				p_cs_n     = 1'b1;
				seq_active = 1'b0;
				ev_cnt     = '0;
				r.done     = 1'b1;
				r.sample   = s;
				r.chan     = seq_ch;
				ended      = 1'b1;
			end
			if (!ended)
				ev_cnt = ev_cnt + 1'b1;
		end
		r.cs_n = p_cs_n;
		r.sclk = p_sclk;
		r.mosi = p_mosi;
		r.busy = seq_active;
	endtask

	task automatic report_mismatch(input string what);
		errors++;
		$display("[%0t] result beat %0d: %s", $realtime, beat_no, what);
	endtask

	task automatic check_field(input string name, input logic [15:0] got,
			input logic [15:0] ref_val);
		if (got !== ref_val)
			report_mismatch($sformatf("%s is %0d, want %0d", name, got, ref_val));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reset_sequencer();
			errors      = 0;
			conversions = 0;
			beat_no     = 0;
			pending <= 0;
		end else begin
			if (cfg_we)
				tol = cfg_wdata;
			if (out_valid && out_ready) begin
				if (pin_state_q.size() == 0) begin
					report_mismatch("result beat with nothing outstanding");
				end else begin
					want = pin_state_q.pop_front();
					check_field("cs_n", cs_n, want.cs_n);
					check_field("sclk", sclk, want.sclk);
					check_field("mosi", mosi, want.mosi);
					check_field("busy_res", busy_res, want.busy);
					check_field("done_res", done_res, want.done);
					check_field("sample", sample, want.sample);
					check_field("sample_channel", sample_channel, want.chan);
					check_field("changed", changed, want.changed);
					if (want.done)
						conversions++;
				end
				beat_no++;
			end
			if (in_valid && in_ready) begin
				step_sequencer(op_t'(operation), channel, miso, next_state);
				pin_state_q.push_back(next_state);
			end
			pending <= pin_state_q.size();
		end
	end

endmodule

@@ test/adc_spi_reader_with_deadband_test.sv @@
`timescale 1ns / 1ps

module adc_spi_reader_with_deadband_test;
	import adcdb_pkg::*;

	localparam int CYCLE_LIMIT    = 200000;
	localparam int RUNS_PER_PHASE = 7;
	localparam int IDLE_PCT       = 6;
	localparam int NOISE_PCT      = 8;
	localparam int DRAIN_CYCLES   = 4;
	localparam int SAMPLE_MAX     = (1 << SAMPLE_W) - 1;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 cfg_we    = 1'b0;
	logic [SAMPLE_W-1:0]  cfg_wdata = '0;
	logic                 in_valid  = 1'b0;
	logic                 in_ready;
	logic                 operation = OP_TICK;
	logic [CH_W-1:0]      channel   = '0;
	logic                 miso      = 1'b0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic                 cs_n;
	logic                 sclk;
	logic                 mosi;
	logic                 busy_res;
	logic                 done_res;
	logic [SAMPLE_W-1:0]  sample;
	logic [CH_W-1:0]      sample_channel;
	logic                 changed;

	int errors;
	int pending;
	int conversions;
	int cycle_count   = 0;
	int beats_sent    = 0;
	int settings_used = 1;

	// no idling on either side while set
	bit calm = 1'b0;

	// stimulus-side memory, used only to aim samples at the deadband edges
	logic [SAMPLE_W-1:0] tol_now = TOL_RESET;
	logic [SAMPLE_W-1:0] last_sent [CHANNELS];

	adc_spi_reader_with_deadband DUT (.*);

	adc_spi_reader_with_deadband_checker checker_i (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Stall the result side now and then, never during a calm stretch.
	always @(posedge clk)
		out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);

	// Hard stop in case the block hangs or drops a result.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
			$display("adc_spi_reader_with_deadband_test: done, errors");
			$finish;
		end
	end

	// Offer one beat and hold it until the block takes it. Call at a rising edge;
	// returns at the edge of acceptance with valid still high.
	task automatic send_beat(input op_t op, input logic [CH_W-1:0] ch, input logic mi);
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		operation <= op;
		channel   <= ch;
		miso      <= mi;
		do
			@(posedge clk);
		while (!in_ready);
		beats_sent++;
	endtask

	// Walk a started conversion through every pin event. The converter word goes
	// out MSB first on the falling-edge ticks; other ticks carry random data.
	task automatic tick_through(input logic [READ_BITS-1:0] word, input int noise_pct);
		int   e;
		logic mi;

		for (e = 0; e <= LAST_EVENT; e++) begin
			// drop in a start while busy; the block must ignore it
			if ($urandom_range(99) < noise_pct)
				send_beat(OP_START, CH_W'($urandom_range(CHANNELS - 1)), 1'($urandom));
			if (e > READ_FIRST_EVENT && e < LAST_EVENT && e % 2 == 1)
				mi = word[READ_BITS - 1 - (e - READ_FIRST_EVENT - 1) / 2];
			else
				mi = 1'($urandom);
			send_beat(OP_TICK, CH_W'($urandom), mi);
		end
	endtask

	task automatic run_conversion(input logic [CH_W-1:0] ch, input logic [READ_BITS-1:0] word,
			input int noise_pct);
		send_beat(OP_START, ch, 1'($urandom));
		tick_through(word, noise_pct);
		last_sent[ch] = word[SAMPLE_W:1];
	endtask

	// Pick a converter word: random a third of the time, else right on or just past the
	// deadband edge of the channel's last sample, equal to it, or at zero or full scale.
	function automatic logic [READ_BITS-1:0] pick_word(input logic [CH_W-1:0] ch);
		int s;
		int d;

		d = $urandom_range(1);
		case ($urandom_range(5))
			0, 1: s = $urandom_range(SAMPLE_MAX);
			2: s = $urandom_range(1) ? 0 : SAMPLE_MAX;
			3: s = int'(last_sent[ch]) + int'(tol_now) + d;
			4: s = int'(last_sent[ch]) - int'(tol_now) - d;
			default: s = int'(last_sent[ch]);
		endcase
		if (s < 0)
			s = 0;
		if (s > SAMPLE_MAX)
			s = SAMPLE_MAX;
		return {1'($urandom), SAMPLE_W'(s), 1'($urandom)};
	endfunction

	// Hold off until every expected result has come back.
	task automatic wait_drained();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
	endtask

	task automatic write_tolerance(input logic [SAMPLE_W-1:0] v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we  <= 1'b0;
		tol_now = v;
		settings_used++;
	endtask

	initial begin
		logic [SAMPLE_W-1:0] tol_plan [4];
		logic [CH_W-1:0]     ch;
		int                  ph;
		int                  run;

		tol_plan = '{SAMPLE_W'(0), SAMPLE_W'(SAMPLE_MAX),
			SAMPLE_W'($urandom_range(2, SAMPLE_MAX - 2)), SAMPLE_W'(1)};
		foreach (last_sent[i])
			last_sent[i] = '0;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, under the reset tolerance.
		// Ticks while idle must leave the pins alone.
		send_beat(OP_TICK, '0, 1'b0);
		send_beat(OP_TICK, '1, 1'b1);
		// Top channel, full-scale word; a second start during the sequence is ignored.
		send_beat(OP_START, CH_W'(CHANNELS - 1), 1'b0);
		send_beat(OP_START, '0, 1'b1);
		tick_through('1, 0);
		last_sent[CHANNELS - 1] = '1;
		// First sample of channel 0 sits on the upper deadband edge: not changed.
		run_conversion('0, {1'b0, SAMPLE_W'(5), 1'b0}, 0);
		// Back to zero: on the lower edge, still not changed.
		run_conversion('0, {1'b1, SAMPLE_W'(0), 1'b1}, 0);
		// One past the edge: changed.
		run_conversion('0, {1'b0, SAMPLE_W'(6), 1'b1}, 0);
		// Full swing down on the top channel.
		run_conversion(CH_W'(CHANNELS - 1), '0, 0);
		// Idle tick after a sequence: data line keeps the last command bit.
		send_beat(OP_TICK, '0, 1'b1);

		// Random part: one phase per tolerance setting, extremes included.
		for (ph = 0; ph < 4; ph++) begin
			wait_drained();
			write_tolerance(tol_plan[ph]);
			// run the full-scale tolerance phase without any idling
			calm = (ph == 1);
			for (run = 0; run < RUNS_PER_PHASE; run++) begin
				if ($urandom_range(3) == 0)
					repeat ($urandom_range(1, 3))
						send_beat(OP_TICK, CH_W'($urandom), 1'($urandom));
				ch = CH_W'($urandom_range(CHANNELS - 1));
				run_conversion(ch, pick_word(ch), NOISE_PCT);
			end
		end
		calm = 1'b0;

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d input beats, %0d finished conversions, %0d tolerance settings",
			beats_sent, conversions, settings_used);
		if (errors == 0)
			$display("adc_spi_reader_with_deadband_test: done, clean");
		else
			$display("adc_spi_reader_with_deadband_test: done, errors");
		$finish;
	end

endmodule

@@ adc_spi_reader_with_deadband.f @@
+incdir+sv
sv/adcdb_pkg.sv
sv/adcdb_seq.sv
sv/adcdb_deadband.sv
sv/adc_spi_reader_with_deadband.sv
test/adc_spi_reader_with_deadband_checker.sv
test/adc_spi_reader_with_deadband_test.sv
